### design/nwh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwh_pkg: shared types and constants for the nearest waypoint snapper.
// Holds the angle formats, the CORDIC arctangent table and the defaults.
// ----------------------------------------------------------------------------
package nwh_pkg;

  // Default sizes for the top-level parameters.
  localparam int MaxWaypointsDefault = 1024;
  localparam int CordicStepsDefault  = 24;

  // Command codes of an input transaction.
  localparam logic CmdWrite = 1'b0;
  localparam logic CmdQuery = 1'b1;

  // One full turn and half a turn in units of 1e-7 degree.
  localparam logic [34:0] FullTurn = 35'd3600000000;
  localparam logic [31:0] HalfTurn = 32'd1800000000;

  // Reciprocal of one full turn: floor(2^64 / full turn).
  localparam logic [32:0] RecipQ64 = 33'd5124095576;

  // Q1.30 constants: one, and the CORDIC gain compensation.
  localparam logic signed [33:0] OneQ30  = 34'sd1073741824;
  localparam logic signed [33:0] GainQ30 = 34'sd652032874;

  // Largest haversine term in unsigned Q0.32.
  localparam logic [35:0] HavMax = 36'd4294967295;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [29:0] atan_turn(input logic [4:0] i);
    logic [29:0] a;
    case (i)
      5'd0:  a = 30'd536870912;
      5'd1:  a = 30'd316933406;
      5'd2:  a = 30'd167458907;
      5'd3:  a = 30'd85004756;
      5'd4:  a = 30'd42667331;
      5'd5:  a = 30'd21354465;
      5'd6:  a = 30'd10679838;
      5'd7:  a = 30'd5340245;
      5'd8:  a = 30'd2670163;
      5'd9:  a = 30'd1335087;
      5'd10: a = 30'd667544;
      5'd11: a = 30'd333772;
      5'd12: a = 30'd166886;
      5'd13: a = 30'd83443;
      5'd14: a = 30'd41722;
      5'd15: a = 30'd20861;
      5'd16: a = 30'd10430;
      5'd17: a = 30'd5215;
      5'd18: a = 30'd2608;
      5'd19: a = 30'd1304;
      5'd20: a = 30'd652;
      5'd21: a = 30'd326;
      5'd22: a = 30'd163;
      5'd23: a = 30'd81;
      5'd24: a = 30'd41;
      5'd25: a = 30'd20;
      5'd26: a = 30'd10;
      5'd27: a = 30'd5;
      5'd28: a = 30'd3;
      5'd29: a = 30'd1;
      5'd30: a = 30'd1;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

endpackage

### design/nwh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwh_ram: generic simple dual-port RAM.
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module nwh_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/nwh_cos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwh_cos: sequential cosine unit.
// Wraps an angle in 1e-7 degree to one turn, converts it to a binary angle
// by reciprocal multiplication with one correction step, then runs a
// rotation-mode CORDIC one step a cycle.
// ----------------------------------------------------------------------------
module nwh_cos #(
  parameter int CordicSteps = nwh_pkg::CordicStepsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [33:0] angle_i,
  output logic               done_o,
  output logic signed [31:0] cos_o
);

  localparam int StepW = $clog2(CordicSteps + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRAP,
    S_MULR,
    S_QEST,
    S_MULQ,
    S_CORR,
    S_PREP,
    S_ROT,
    S_FIN
  } state_e;

  state_e             state_q;
  logic signed [34:0] r_q;
  logic [31:0]        rw_q;
  logic [64:0]        rm_q;
  logic [32:0]        qe_q;
  logic [64:0]        qf_q;
  logic [31:0]        quo_q;
  logic [StepW-1:0]   step_q;
  logic [1:0]         quad_q;
  logic signed [33:0] x_q, y_q, z_q;
  logic               done_q;
  logic signed [31:0] cos_q;

  logic [64:0]        num_d;
  logic [64:0]        lim_d;
  logic [31:0]        t_rnd;
  logic [1:0]         quad_d;
  logic [31:0]        u_d;
  logic signed [33:0] dx, dy, zstep;
  logic signed [33:0] c_sel;

  // Dividend r * 2^32 + half turn, and the bound for one more quotient step.
  assign num_d = {1'b0, rw_q, 32'd0} + 65'(nwh_pkg::HalfTurn);
  assign lim_d = qf_q + 65'(nwh_pkg::FullTurn);

  // Quarter-turn selection and residual angle.
  assign t_rnd  = quo_q + 32'h2000_0000;
  assign quad_d = t_rnd[31:30];
  assign u_d    = quo_q - {quad_d, 30'd0};

  // Shared CORDIC shifter.
  assign dx    = y_q >>> step_q;
  assign dy    = x_q >>> step_q;
  assign zstep = signed'({4'd0, nwh_pkg::atan_turn(5'(step_q))});

  // Quadrant fold of the rotated vector.
  always_comb begin
    case (quad_q)
      2'd0:    c_sel = x_q;
      2'd1:    c_sel = -y_q;
      2'd2:    c_sel = -x_q;
      default: c_sel = y_q;
    endcase
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      r_q     <= '0;
      rw_q    <= '0;
      rm_q    <= '0;
      qe_q    <= '0;
      qf_q    <= '0;
      quo_q   <= '0;
      step_q  <= '0;
      quad_q  <= '0;
      x_q     <= '0;
      y_q     <= '0;
      z_q     <= '0;
      done_q  <= 1'b0;
      cos_q   <= '0;
    end else begin
      done_q <= (state_q == S_FIN);
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            r_q     <= 35'(angle_i);
            state_q <= S_WRAP;
          end
        end
        // Bring the angle into one turn by adding or removing full turns.
        S_WRAP: begin
          if (r_q < 0) begin
            r_q <= r_q + signed'(nwh_pkg::FullTurn);
          end else if (r_q >= signed'(nwh_pkg::FullTurn)) begin
            r_q <= r_q - signed'(nwh_pkg::FullTurn);
          end else begin
            rw_q    <= r_q[31:0];
            state_q <= S_MULR;
          end
        end
        // Estimate the rounded quotient with the reciprocal of a full turn.
        S_MULR: begin
          rm_q    <= 65'(rw_q) * 65'(nwh_pkg::RecipQ64);
          state_q <= S_QEST;
        end
        // The estimate is exact or one too small.
        S_QEST: begin
          qe_q    <= 33'((rm_q + 65'h0_8000_0000) >> 32);
          state_q <= S_MULQ;
        end
        S_MULQ: begin
          qf_q    <= 65'(qe_q) * 65'(nwh_pkg::FullTurn[31:0]);
          state_q <= S_CORR;
        end
        // Add one when another full turn still fits in the dividend.
        S_CORR: begin
          if (num_d >= lim_d) begin
            quo_q <= qe_q[31:0] + 32'd1;
          end else begin
            quo_q <= qe_q[31:0];
          end
          state_q <= S_PREP;
        end
        S_PREP: begin
          quad_q  <= quad_d;
          z_q     <= 34'(signed'(u_d));
          x_q     <= nwh_pkg::GainQ30;
          y_q     <= '0;
          step_q  <= '0;
          state_q <= S_ROT;
        end
        // One CORDIC rotation per cycle.
        S_ROT: begin
          if (!z_q[33]) begin
            x_q <= x_q - dx;
            y_q <= y_q + dy;
            z_q <= z_q - zstep;
          end else begin
            x_q <= x_q + dx;
            y_q <= y_q - dy;
            z_q <= z_q + zstep;
          end
          step_q <= step_q + StepW'(1);
          if (step_q == StepW'(CordicSteps - 1)) begin
            state_q <= S_FIN;
          end
        end
        // Fold the quadrant back and clamp to plus or minus one.
        S_FIN: begin
          if (c_sel > nwh_pkg::OneQ30) begin
            cos_q <= 32'(nwh_pkg::OneQ30);
          end else if (c_sel < -nwh_pkg::OneQ30) begin
            cos_q <= 32'(-nwh_pkg::OneQ30);
          end else begin
            cos_q <= 32'(c_sel);
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign cos_o  = cos_q;

endmodule

### design/nearest_waypoint_haversine.sv
`timescale 1ns / 1ps
// A write transaction is stored at the edge that accepts it, and the
// next transaction can be taken in the following cycle.
// A query first takes the cosine of the fix latitude, then for each scanned waypoint
// runs the shared cosine unit on the latitude and longitude differences and the
// waypoint latitude, then hands the result to the output register. One transaction is
// processed at a time. Reset clears the count; the tables are undefined until written.
// ----------------------------------------------------------------------------
// nearest_waypoint_haversine: nearest waypoint by haversine term.
// Stores waypoints and, for a query fix, scans the table for the least
// great-circle distance, the first minimum winning a tie.
// ----------------------------------------------------------------------------
module nearest_waypoint_haversine #(
  parameter int MAX_WAYPOINTS = nwh_pkg::MaxWaypointsDefault,
  parameter int CORDIC_STEPS  = nwh_pkg::CordicStepsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [10:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cmd_i,
  input  logic [9:0]         index_i,
  input  logic signed [30:0] lat_i,
  input  logic signed [31:0] lon_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [30:0] snap_lat_o,
  output logic signed [31:0] snap_lon_o,
  output logic [9:0]         nearest_index_o,
  output logic               matched_o
);

  localparam int AddrW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
  localparam int CntW  = $clog2(MAX_WAYPOINTS + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_COS1,
    S_READ,
    S_LOAD,
    S_COSLAT,
    S_COSLON,
    S_COS2,
    S_MUL1,
    S_MUL2,
    S_CMP,
    S_OUT
  } state_e;

  state_e             state_q;
  logic [10:0]        count_q;
  logic signed [30:0] lat1_q;
  logic signed [31:0] lon1_q;
  logic [CntW-1:0]    n_q;
  logic [CntW-1:0]    idx_q;
  logic signed [30:0] wl_q;
  logic signed [31:0] wo_q;
  logic               busy_q;
  logic               start_q;
  logic signed [33:0] angle_q;
  logic signed [31:0] c1_q, c2_q, p_q;
  logic signed [33:0] hlat_q, hlon_q;
  logic signed [34:0] t_q;
  logic               found_q;
  logic [31:0]        best_a_q;
  logic signed [30:0] best_lat_q;
  logic signed [31:0] best_lon_q;
  logic [CntW-1:0]    best_idx_q;
  logic               out_valid_q;
  logic signed [30:0] out_lat_q;
  logic signed [31:0] out_lon_q;
  logic [9:0]         out_idx_q;
  logic               out_match_q;

  logic               in_acc;
  logic               ram_we;
  logic [AddrW-1:0]   ram_raddr;
  logic [31:0]        lat_rdata, lon_rdata;
  logic               cos_done;
  logic signed [31:0] cos_val;
  logic               cos_req;
  logic               out_load;
  logic signed [33:0] hav_d;
  logic signed [63:0] prod1;
  logic signed [67:0] prod2;
  logic signed [35:0] sum_d;
  logic [31:0]        a_d;
  logic [CntW-1:0]    n_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Table writes for in-range slots.
  assign ram_we    = in_acc && (cmd_i == nwh_pkg::CmdWrite)
                     && (32'(index_i) < 32'(MAX_WAYPOINTS));
  assign ram_raddr = AddrW'(idx_q);

  nwh_ram #(.Width(32), .Depth(MAX_WAYPOINTS)) u_lat_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AddrW'(index_i)),
    .wdata_i (32'(lat_i)),
    .raddr_i (ram_raddr),
    .rdata_o (lat_rdata)
  );

  nwh_ram #(.Width(32), .Depth(MAX_WAYPOINTS)) u_lon_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AddrW'(index_i)),
    .wdata_i (lon_i),
    .raddr_i (ram_raddr),
    .rdata_o (lon_rdata)
  );

  nwh_cos #(.CordicSteps(CORDIC_STEPS)) u_cos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .angle_i (angle_q),
    .done_o  (cos_done),
    .cos_o   (cos_val)
  );

  // A cosine state starts the shared unit through the registered start_q, set while the unit is not busy.
  assign cos_req = (state_q == S_COS1) || (state_q == S_COSLAT)
                   || (state_q == S_COSLON) || (state_q == S_COS2);

  // The result register takes a new result once it is free or being drained.
  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  // Scan length saturates at the table size.
  assign n_d = (32'(count_q) > 32'(MAX_WAYPOINTS)) ? CntW'(MAX_WAYPOINTS)
                                                    : CntW'(count_q);

  // Haversine of a cosine: (1 - cos) / 2 in Q0.32.
  assign hav_d = (nwh_pkg::OneQ30 - 34'(cos_val)) <<< 1;

  // Products and the clamped sum.
  assign prod1 = 64'(c1_q) * 64'(c2_q);
  assign prod2 = 68'(p_q) * 68'(hlon_q);
  assign sum_d = 36'(hlat_q) + 36'(t_q);
  always_comb begin
    if (sum_d < 0) begin
      a_d = '0;
    end else if (sum_d > signed'(nwh_pkg::HavMax)) begin
      a_d = 32'hFFFF_FFFF;
    end else begin
      a_d = sum_d[31:0];
    end
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      count_q <= cfg_data_i;
    end
  end

  // Query sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lat1_q      <= '0;
      lon1_q      <= '0;
      n_q         <= '0;
      idx_q       <= '0;
      wl_q        <= '0;
      wo_q        <= '0;
      busy_q      <= 1'b0;
      start_q     <= 1'b0;
      angle_q     <= '0;
      c1_q        <= '0;
      c2_q        <= '0;
      p_q         <= '0;
      hlat_q      <= '0;
      hlon_q      <= '0;
      t_q         <= '0;
      found_q     <= 1'b0;
      best_a_q    <= '0;
      best_lat_q  <= '0;
      best_lon_q  <= '0;
      best_idx_q  <= '0;
      out_valid_q <= 1'b0;
      out_lat_q   <= '0;
      out_lon_q   <= '0;
      out_idx_q   <= '0;
      out_match_q <= 1'b0;
    end else begin
      start_q <= cos_req && !busy_q;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc && (cmd_i == nwh_pkg::CmdQuery)) begin
            lat1_q  <= lat_i;
            lon1_q  <= lon_i;
            n_q     <= n_d;
            idx_q   <= '0;
            found_q <= 1'b0;
            state_q <= S_COS1;
          end
        end
        // Cosine of the fix latitude, once per query.
        S_COS1: begin
          if (!busy_q) begin
            angle_q <= 34'(lat1_q);
            busy_q  <= 1'b1;
          end else if (cos_done) begin
            c1_q    <= cos_val;
            busy_q  <= 1'b0;
            state_q <= S_READ;
          end
        end
        // Present the next slot to the tables, or finish the scan.
        S_READ: begin
          if (idx_q == n_q) begin
            state_q <= S_OUT;
          end else begin
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          wl_q    <= lat_rdata[30:0];
          wo_q    <= lon_rdata;
          state_q <= S_COSLAT;
        end
        S_COSLAT: begin
          if (!busy_q) begin
            angle_q <= 34'(wl_q) - 34'(lat1_q);
            busy_q  <= 1'b1;
          end else if (cos_done) begin
            hlat_q  <= hav_d;
            busy_q  <= 1'b0;
            state_q <= S_COSLON;
          end
        end
        S_COSLON: begin
          if (!busy_q) begin
            angle_q <= 34'(wo_q) - 34'(lon1_q);
            busy_q  <= 1'b1;
          end else if (cos_done) begin
            hlon_q  <= hav_d;
            busy_q  <= 1'b0;
            state_q <= S_COS2;
          end
        end
        S_COS2: begin
          if (!busy_q) begin
            angle_q <= 34'(wl_q);
            busy_q  <= 1'b1;
          end else if (cos_done) begin
            c2_q    <= cos_val;
            busy_q  <= 1'b0;
            state_q <= S_MUL1;
          end
        end
        S_MUL1: begin
          p_q     <= 32'(prod1 >>> 30);
          state_q <= S_MUL2;
        end
        S_MUL2: begin
          t_q     <= 35'(prod2 >>> 30);
          state_q <= S_CMP;
        end
        // Strict compare keeps the first minimum.
        S_CMP: begin
          if (!found_q || (a_d < best_a_q)) begin
            found_q    <= 1'b1;
            best_a_q   <= a_d;
            best_lat_q <= wl_q;
            best_lon_q <= wo_q;
            best_idx_q <= idx_q;
          end
          idx_q   <= idx_q + CntW'(1);
          state_q <= S_READ;
        end
        // Hand the result to the output register once it is free.
        S_OUT: begin
          if (out_load) begin
            out_match_q <= found_q;
            if (found_q) begin
              out_lat_q <= best_lat_q;
              out_lon_q <= best_lon_q;
              out_idx_q <= 10'(best_idx_q);
            end else begin
              out_lat_q <= lat1_q;
              out_lon_q <= lon1_q;
              out_idx_q <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign snap_lat_o      = out_lat_q;
  assign snap_lon_o      = out_lon_q;
  assign nearest_index_o = out_idx_q;
  assign matched_o       = out_match_q;

endmodule
